// ===== sv/bcc_pkg.sv =====
// Shared types and constants of the barometer compensation core.
// No dependencies; used by the top level and the sequencer.
package bcc_pkg;

  // Calibration register indexes on the configuration port
  localparam logic [2:0] REG_T1  = 3'd0;
  localparam logic [2:0] REG_T2  = 3'd1;
  localparam logic [2:0] REG_T3  = 3'd2;
  localparam logic [2:0] REG_P1  = 3'd3;
  localparam logic [2:0] REG_P23 = 3'd4;
  localparam logic [2:0] REG_P45 = 3'd5;
  localparam logic [2:0] REG_P67 = 3'd6;
  localparam logic [2:0] REG_P89 = 3'd7;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Request / result kind
  localparam logic KIND_TEMP  = 1'b0;
  localparam logic KIND_PRESS = 1'b1;

  // Calibration words as handed to the sequencer
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [31:0] p23;
    logic [31:0] p45;
    logic [31:0] p67;
    logic [31:0] p89;
  } bcc_coef_t;

endpackage

// ===== sv/bcc_mul.sv =====
// Shared 64x64 (low 64 bits) multiplier built on one 32x32 multiplier.
// No package dependencies.
module bcc_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] res_o
);

  logic [63:0] a_q, b_q, prod_q, prod_d, acc_q;
  logic [31:0] mx, my;
  logic [1:0]  cnt_q;
  logic        busy_q, done_q;

  // partial product select: lo*lo, lo*hi, hi*lo
  always_comb begin
    case (cnt_q)
      2'd0: begin
        mx = a_q[31:0];
        my = b_q[31:0];
      end
      2'd1: begin
        mx = a_q[31:0];
        my = b_q[63:32];
      end
      default: begin
        mx = a_q[63:32];
        my = b_q[31:0];
      end
    endcase
    prod_d = mx * my;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 2'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (busy_q) begin
      prod_q <= prod_d;
      case (cnt_q)
        2'd0:    acc_q <= acc_q;
        2'd1:    acc_q <= prod_q;
        default: acc_q <= acc_q + {prod_q[31:0], 32'b0};
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

// ===== sv/bcc_div.sv =====
// Signed 64-bit divider, truncating toward zero, one quotient bit a cycle.
// No package dependencies; divisor must be nonzero.
module bcc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] res_o
);

  logic [63:0] n_q, d_q, rem_q;
  logic [64:0] trial;
  logic [5:0]  cnt_q;
  logic        neg_q, busy_q, done_q, qbit;

  // restoring step
  always_comb begin
    trial = {rem_q, n_q[63]} - {1'b0, d_q};
    qbit  = ~trial[64];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 6'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // magnitudes in, quotient shifts into the dividend register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= a_i[63] ? (64'd0 - a_i) : a_i;
      d_q   <= b_i[63] ? (64'd0 - b_i) : b_i;
      neg_q <= a_i[63] ^ b_i[63];
      rem_q <= 64'd0;
    end else if (busy_q) begin
      rem_q <= qbit ? trial[63:0] : {rem_q[62:0], n_q[63]};
      n_q   <= {n_q[62:0], qbit};
    end
  end

  assign done_o = done_q;
  assign res_o  = neg_q ? (64'd0 - n_q) : n_q;

endmodule

// ===== sv/bcc_seq.sv =====
// Step sequencer and register file for the compensation formulas.
// Depends on bcc_pkg, bcc_mul and bcc_div.
module bcc_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              req_type_i,
  input  logic [19:0]       raw_sample_i,
  input  bcc_pkg::bcc_coef_t coef_i,
  input  logic              out_free_i,
  output logic              idle_o,
  output logic              done_o,
  output logic              kind_o,
  output logic [31:0]       temp_o,
  output logic [31:0]       press_o,
  output logic              guard_o
);
  import bcc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  // step codes: temperature 0..3, pressure 4..15
  localparam logic [3:0] T0 = 4'd0,  T1 = 4'd1,  T2 = 4'd2,  T3 = 4'd3;
  localparam logic [3:0] P0 = 4'd4,  P1 = 4'd5,  P2 = 4'd6,  P3 = 4'd7;
  localparam logic [3:0] P4 = 4'd8,  P5 = 4'd9,  P6 = 4'd10, P7 = 4'd11;
  localparam logic [3:0] P8 = 4'd12, P9 = 4'd13, P10 = 4'd14, P11 = 4'd15;

  function automatic logic [63:0] sx16(input logic [15:0] v);
    sx16 = {{48{v[15]}}, v};
  endfunction

  state_e      state_q, state_d;
  logic [3:0]  pc_q, pc_d;
  logic [19:0] raw_q;
  logic [31:0] fine_q, fine_d;
  logic [63:0] ra_q, ra_d, rv1_q, rv1_d, rsq_q, rsq_d, rv2_q, rv2_d;
  logic [63:0] rx_q, rx_d, rdv_q, rdv_d, rp_q, rp_d;
  logic        kind_q, kind_d, guard_q, guard_d;
  logic [31:0] temp_q, temp_d, press_q, press_d;

  logic        mul_start, div_start, mul_done, div_done;
  logic [63:0] mul_a, mul_b, mul_res, div_res;

  // operand helpers
  logic [31:0] t1_32, a_t, d_t, fine_n, t5;
  logic [63:0] res, dv, p64, sum_p, out_p;

  assign res    = mul_res;
  assign t1_32  = {16'b0, coef_i.t1};
  assign a_t    = {15'b0, raw_q[19:3]} - {t1_32[30:0], 1'b0};
  assign d_t    = {16'b0, raw_q[19:4]} - t1_32;
  assign fine_n = ra_q[31:0] + 32'($signed(res[31:0]) >>> 14);
  assign t5     = fine_n + {fine_n[29:0], 2'b0} + 32'd128;
  assign dv     = 64'($signed(res) >>> 33);
  assign p64    = 64'd1048576 - {44'b0, raw_q};
  assign sum_p  = rp_q + rx_q + 64'($signed(res) >>> 19);
  assign out_p  = 64'($signed(sum_p) >>> 8) + {sx16(coef_i.p67[15:0]) << 4};

  always_comb begin
    state_d   = state_q;
    pc_d      = pc_q;
    fine_d    = fine_q;
    ra_d      = ra_q;
    rv1_d     = rv1_q;
    rsq_d     = rsq_q;
    rv2_d     = rv2_q;
    rx_d      = rx_q;
    rdv_d     = rdv_q;
    rp_d      = rp_q;
    kind_d    = kind_q;
    guard_d   = guard_q;
    temp_d    = temp_q;
    press_d   = press_q;
    mul_start = 1'b0;
    mul_a     = 64'd0;
    mul_b     = 64'd0;
    div_start = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_EXEC;
          pc_d    = (req_type_i == KIND_PRESS) ? P0 : T0;
        end
      end
      S_EXEC: begin
        // most steps absorb the last product and launch the next one
        state_d = S_MUL;
        pc_d    = pc_q + 4'd1;
        case (pc_q)
          T0: begin
            mul_start = 1'b1;
            mul_a     = {32'b0, a_t};
            mul_b     = sx16(coef_i.t2);
          end
          T1: begin
            ra_d      = {32'b0, 32'($signed(res[31:0]) >>> 11)};
            mul_start = 1'b1;
            mul_a     = {32'b0, d_t};
            mul_b     = {32'b0, d_t};
          end
          T2: begin
            mul_start = 1'b1;
            mul_a     = {32'b0, 32'($signed(res[31:0]) >>> 12)};
            mul_b     = sx16(coef_i.t3);
          end
          T3: begin
            fine_d  = fine_n;
            kind_d  = KIND_TEMP;
            temp_d  = 32'($signed(t5) >>> 8);
            press_d = 32'd0;
            guard_d = 1'b0;
            state_d = S_DONE;
          end
          P0: begin
            rv1_d     = {{32{fine_q[31]}}, fine_q} - 64'd128000;
            mul_start = 1'b1;
            mul_a     = rv1_d;
            mul_b     = rv1_d;
          end
          P1: begin
            rsq_d     = res;
            mul_start = 1'b1;
            mul_a     = res;
            mul_b     = sx16(coef_i.p67[31:16]);
          end
          P2: begin
            rv2_d     = res;
            mul_start = 1'b1;
            mul_a     = rv1_q;
            mul_b     = sx16(coef_i.p45[15:0]);
          end
          P3: begin
            rv2_d     = rv2_q + {res[46:0], 17'b0} +
                        {sx16(coef_i.p45[31:16]) << 35};
            mul_start = 1'b1;
            mul_a     = rsq_q;
            mul_b     = sx16(coef_i.p23[15:0]);
          end
          P4: begin
            rx_d      = 64'($signed(res) >>> 8);
            mul_start = 1'b1;
            mul_a     = rv1_q;
            mul_b     = sx16(coef_i.p23[31:16]);
          end
          P5: begin
            mul_start = 1'b1;
            mul_a     = rx_q + {res[51:0], 12'b0} + 64'h0000_8000_0000_0000;
            mul_b     = {48'b0, coef_i.p1};
          end
          P6: begin
            rdv_d = dv;
            if (dv == 64'd0) begin
              // zero divisor: forced result
              kind_d  = KIND_PRESS;
              temp_d  = 32'd0;
              press_d = 32'd0;
              guard_d = 1'b1;
              state_d = S_DONE;
            end else begin
              mul_start = 1'b1;
              mul_a     = {p64[32:0], 31'b0} - rv2_q;
              mul_b     = 64'd3125;
            end
          end
          P7: begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
          P8: begin
            rp_d      = div_res;
            ra_d      = 64'($signed(div_res) >>> 13);
            mul_start = 1'b1;
            mul_a     = sx16(coef_i.p89[15:0]);
            mul_b     = ra_d;
          end
          P9: begin
            mul_start = 1'b1;
            mul_a     = res;
            mul_b     = ra_q;
          end
          P10: begin
            rx_d      = 64'($signed(res) >>> 25);
            mul_start = 1'b1;
            mul_a     = sx16(coef_i.p89[31:16]);
            mul_b     = rp_q;
          end
          P11: begin
            kind_d  = KIND_PRESS;
            temp_d  = 32'd0;
            press_d = out_p[31:0];
            guard_d = 1'b0;
            state_d = S_DONE;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_MUL: begin
        if (mul_done) state_d = S_EXEC;
      end
      S_DIV: begin
        if (div_done) state_d = S_EXEC;
      end
      S_DONE: begin
        if (out_free_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control and stored fine temperature
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= T0;
      fine_q  <= 32'd0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      fine_q  <= fine_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (start_i) raw_q <= raw_sample_i;
    ra_q    <= ra_d;
    rv1_q   <= rv1_d;
    rsq_q   <= rsq_d;
    rv2_q   <= rv2_d;
    rx_q    <= rx_d;
    rdv_q   <= rdv_d;
    rp_q    <= rp_d;
    kind_q  <= kind_d;
    guard_q <= guard_d;
    temp_q  <= temp_d;
    press_q <= press_d;
  end

  bcc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  bcc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_i     (res),
    .b_i     (rdv_q),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  assign idle_o  = (state_q == S_IDLE);
  assign done_o  = (state_q == S_DONE) && out_free_i;
  assign kind_o  = kind_q;
  assign temp_o  = temp_q;
  assign press_o = press_q;
  assign guard_o = guard_q;

endmodule

// ===== sv/barometer_compensation_core.sv =====
// Barometer compensation core: one request at a time through a shared
// 32x32 multiplier, which builds each 64-bit product, and a bit-serial
// divider. A pressure request runs ten products on the shared multiplier
// and 64 divider steps; a zero divisor ends a pressure request after six
// products. in_stall_o stays high from acceptance until the result is loaded
// into the output register, which holds it until taken while the next request
// is accepted. Pressure uses the fine temperature of the last temperature
// request (zero after reset). Depends on bcc_pkg and bcc_seq.
module barometer_compensation_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [19:0]                   raw_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          result_kind_o,
  output logic signed [31:0]            temperature_centi_o,
  output logic [31:0]                   pressure_q24_8_o,
  output logic                          division_guarded_o,
  input  logic                          cfg_we_i,
  input  logic [bcc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bcc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import bcc_pkg::*;

  bcc_coef_t   coef_q;
  logic        out_valid_q, out_free, seq_idle, seq_done, start;
  logic        seq_kind, seq_guard;
  logic [31:0] seq_temp, seq_press;
  logic        kind_q, guard_q;
  logic [31:0] temp_q, press_q;

  // calibration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_T1:  coef_q.t1  <= cfg_data_i[15:0];
        REG_T2:  coef_q.t2  <= cfg_data_i[15:0];
        REG_T3:  coef_q.t3  <= cfg_data_i[15:0];
        REG_P1:  coef_q.p1  <= cfg_data_i[15:0];
        REG_P23: coef_q.p23 <= cfg_data_i;
        REG_P45: coef_q.p45 <= cfg_data_i;
        REG_P67: coef_q.p67 <= cfg_data_i;
        REG_P89: coef_q.p89 <= cfg_data_i;
        default: coef_q <= coef_q;
      endcase
    end
  end

  assign start    = in_valid_i && seq_idle;
  assign out_free = !out_valid_q || !out_stall_i;

  bcc_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .req_type_i   (req_type_i),
    .raw_sample_i (raw_sample_i),
    .coef_i       (coef_q),
    .out_free_i   (out_free),
    .idle_o       (seq_idle),
    .done_o       (seq_done),
    .kind_o       (seq_kind),
    .temp_o       (seq_temp),
    .press_o      (seq_press),
    .guard_o      (seq_guard)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_done) begin
      kind_q  <= seq_kind;
      temp_q  <= seq_temp;
      press_q <= seq_press;
      guard_q <= seq_guard;
    end
  end

  assign in_stall_o          = !seq_idle;
  assign out_valid_o         = out_valid_q;
  assign result_kind_o       = kind_q;
  assign temperature_centi_o = temp_q;
  assign pressure_q24_8_o    = press_q;
  assign division_guarded_o  = guard_q;

endmodule

// ===== sv/bcc_chk.sv =====
// Port-level checker for the barometer compensation core, with its bind.
// Depends on bcc_pkg for the configuration port widths.
module bcc_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          req_type_i,
  input logic [19:0]                   raw_sample_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          result_kind_o,
  input logic [31:0]                   temperature_centi_o,
  input logic [31:0]                   pressure_q24_8_o,
  input logic                          division_guarded_o,
  input logic                          cfg_we_i,
  input logic [bcc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input logic [bcc_pkg::CfgDataW-1:0]  cfg_data_i
);

  // one request at a time: busy right after acceptance
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while busy window expected");

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(pressure_q24_8_o)
      && $stable(temperature_centi_o)))
    else $error("stalled result dropped or changed");

  // temperature results carry no pressure and no guard
  a_temp_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !result_kind_o) |-> (pressure_q24_8_o == 32'd0 &&
      !division_guarded_o))
    else $error("temperature result with pressure fields set");

  // guarded results are pressure results forced to zero
  a_guard_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && division_guarded_o) |-> (result_kind_o &&
      pressure_q24_8_o == 32'd0 && temperature_centi_o == 32'd0))
    else $error("guarded result not zero");

endmodule

bind barometer_compensation_core bcc_chk u_bcc_chk (.*);

// ===== dv/barometer_compensation_core_tb.sv =====
// Testbench for barometer_compensation_core: random and directed requests,
// an in-bench compensation predictor and a result scoreboard.
// Depends on bcc_pkg and the core RTL.
`timescale 1ns / 1ps

module barometer_compensation_core_tb;
  import bcc_pkg::*;

  typedef struct {
    logic        kind;
    logic [19:0] sample;
  } conv_req_t;

  typedef struct {
    logic        kind;
    logic [31:0] temp_centi;
    logic [31:0] press_q;
    logic        guarded;
  } conv_res_t;

  logic clk_i, rst_ni;
  logic in_valid, in_stall;
  logic req_type;
  logic [19:0] raw_sample;
  logic out_valid, out_stall;
  logic res_kind, res_guard;
  logic signed [31:0] res_temp;
  logic [31:0] res_press;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  conv_req_t pending_reqs[$];
  conv_res_t expected_res[$];
  logic [31:0] calib[8];
  int fine_temp;
  int fails;
  int results_seen;
  int idle_cycles;
  int tx_gap, rx_gap, rx_hold;
  bit hold_done;
  bit quiet;

  barometer_compensation_core u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .req_type_i          (req_type),
    .raw_sample_i        (raw_sample),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .result_kind_o       (res_kind),
    .temperature_centi_o (res_temp),
    .pressure_q24_8_o    (res_press),
    .division_guarded_o  (res_guard),
    .cfg_we_i            (cfg_we),
    .cfg_idx_i           (cfg_idx),
    .cfg_data_i          (cfg_data)
  );

  // Clock and reset
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Temperature formula; updates the fine temperature
  function automatic logic [31:0] calc_temperature(logic [19:0] sample);
    int adc, t1, t2, t3, a, v1, d, v2;
    adc = int'({12'd0, sample});
    t1  = int'({16'd0, calib[REG_T1][15:0]});
    t2  = int'($signed(calib[REG_T2][15:0]));
    t3  = int'($signed(calib[REG_T3][15:0]));
    a   = (adc >> 3) - (t1 << 1);
    v1  = (a * t2) >>> 11;
    d   = (adc >> 4) - t1;
    v2  = (((d * d) >>> 12) * t3) >>> 14;
    fine_temp = v1 + v2;
    return (fine_temp * 5 + 128) >>> 8;
  endfunction

  // Pressure formula on the stored fine temperature
  function automatic logic [31:0] calc_pressure(logic [19:0] sample, output logic guard);
    longint p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, num;
    p1 = longint'({48'd0, calib[REG_P1][15:0]});
    p2 = longint'($signed(calib[REG_P23][31:16]));
    p3 = longint'($signed(calib[REG_P23][15:0]));
    p4 = longint'($signed(calib[REG_P45][31:16]));
    p5 = longint'($signed(calib[REG_P45][15:0]));
    p6 = longint'($signed(calib[REG_P67][31:16]));
    p7 = longint'($signed(calib[REG_P67][15:0]));
    p8 = longint'($signed(calib[REG_P89][31:16]));
    p9 = longint'($signed(calib[REG_P89][15:0]));
    v1 = longint'(fine_temp) - 64'sd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) <<< 17);
    v2 = v2 + (p4 <<< 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
    v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
    if (v1 == 0) begin
      guard = 1'b1;
      return 32'd0;
    end
    guard = 1'b0;
    p   = 64'sd1048576 - longint'({44'd0, sample});
    num = ((p <<< 31) - v2) * 64'sd3125;
    // most negative dividend over minus one wraps
    if (v1 == -64'sd1) p = -num;
    else p = num / v1;
    v1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
    v2 = (p8 * p) >>> 19;
    p  = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
    return p[31:0];
  endfunction

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    conv_req_t r;
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      req_type   <= KIND_TEMP;
      raw_sample <= '0;
      tx_gap     <= 0;
    end else if (!in_valid || !in_stall) begin
      if (tx_gap > 0) begin
        tx_gap   <= tx_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        req_type   <= r.kind;
        raw_sample <= r.sample;
        in_valid   <= 1'b1;
        if (!quiet && $urandom_range(3) == 0) tx_gap <= $urandom_range(1, 7);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Predict on each accepted request
  always @(posedge clk_i) begin
    conv_res_t e;
    if (rst_ni && in_valid && !in_stall) begin
      e.kind = req_type;
      if (req_type == KIND_TEMP) begin
        e.temp_centi = calc_temperature(raw_sample);
        e.press_q    = '0;
        e.guarded    = 1'b0;
      end else begin
        e.temp_centi = '0;
        e.press_q    = calc_pressure(raw_sample, e.guarded);
      end
      expected_res.push_back(e);
    end
  end

  // Result monitor with random stalls and one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    conv_res_t e;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      rx_gap    <= 0;
      rx_hold   <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_res.size() == 0) begin
          $error("result with nothing expected");
          fails++;
        end else begin
          e = expected_res.pop_front();
          if (res_kind !== e.kind) begin
            $error("result_kind exp %0d got %0d", e.kind, res_kind);
            fails++;
          end
          if (res_temp !== e.temp_centi) begin
            $error("temperature_centi exp %0d got %0d", $signed(e.temp_centi), res_temp);
            fails++;
          end
          if (res_press !== e.press_q) begin
            $error("pressure_q24_8 exp %h got %h", e.press_q, res_press);
            fails++;
          end
          if (res_guard !== e.guarded) begin
            $error("division_guarded exp %0d got %0d", e.guarded, res_guard);
            fails++;
          end
        end
      end
      if (!hold_done && results_seen == 60) begin
        hold_done <= 1'b1;
        rx_hold   <= 400;
        out_stall <= 1'b1;
      end else if (rx_hold > 0) begin
        rx_hold   <= rx_hold - 1;
        out_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap    <= rx_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(4) == 0) begin
        rx_gap    <= $urandom_range(0, 6);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Write all calibration registers, block idle
  task automatic load_calib(input logic [31:0] vals[8]);
    for (int i = 0; i < 8; i++) begin
      @(posedge clk_i);
      cfg_we   <= 1'b1;
      cfg_idx  <= CfgIdxW'(i);
      cfg_data <= vals[i];
      calib[i] = (i < 4) ? {16'd0, vals[i][15:0]} : vals[i];
    end
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic add_req(input logic kind, input logic [19:0] sample);
    conv_req_t r;
    r.kind   = kind;
    r.sample = sample;
    pending_reqs.push_back(r);
  endtask

  // Sender waits here until every expected result has come
  task automatic drain();
    wait (pending_reqs.size() == 0 && !in_valid);
    wait (expected_res.size() == 0);
    repeat (150) @(posedge clk_i);
  endtask

  // Calibration near a typical sensor, with random spread
  task automatic near_typical(output logic [31:0] v[8]);
    v[REG_T1]  = {16'($urandom_range(65535)), 16'd27504 + 16'($urandom_range(2000))};
    v[REG_T2]  = {16'($urandom), 16'd26000 + 16'($urandom_range(1000))};
    v[REG_T3]  = {16'($urandom), 16'hFC18 + 16'($urandom_range(1000))};
    v[REG_P1]  = {16'($urandom), 16'd36000 + 16'($urandom_range(1000))};
    v[REG_P23] = {16'hD643 + 16'($urandom_range(500)), 16'd3024 + 16'($urandom_range(200))};
    v[REG_P45] = {16'd2855 + 16'($urandom_range(500)), 16'd140 + 16'($urandom_range(100))};
    v[REG_P67] = {16'hFFF9, 16'd15500 + 16'($urandom_range(500))};
    v[REG_P89] = {16'hC6F8 + 16'($urandom_range(500)), 16'd6000 + 16'($urandom_range(500))};
  endtask

  // Stimulus
  initial begin
    logic [31:0] v[8];
    fails = 0;
    results_seen = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    fine_temp = 0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    for (int i = 0; i < 8; i++) calib[i] = '0;
    wait (rst_ni);
    @(posedge clk_i);

    // reset calibration: pressure before any temperature, zero divisor
    add_req(KIND_PRESS, 20'd415148);
    add_req(KIND_TEMP, 20'd0);
    add_req(KIND_PRESS, 20'hFFFFF);
    drain();

    // typical calibration, field extremes
    v = '{32'd27504, 32'd26435, 32'hFFFF_FC18, 32'd36477,
          32'hD643_0BD0, 32'h0B27_008C, 32'hFFF9_3C8C, 32'hC6F8_1770};
    load_calib(v);
    add_req(KIND_PRESS, 20'd415148);
    add_req(KIND_TEMP, 20'd519888);
    add_req(KIND_PRESS, 20'd415148);
    add_req(KIND_TEMP, 20'd0);
    add_req(KIND_PRESS, 20'd0);
    add_req(KIND_TEMP, 20'hFFFFF);
    add_req(KIND_PRESS, 20'hFFFFF);
    add_req(KIND_PRESS, 20'h80000);
    drain();

    // extreme calibration: all maxima, then all minima but p1 = 1
    v = '{32'hFFFF_FFFF, 32'h0000_7FFF, 32'h0000_7FFF, 32'hFFFF_FFFF,
          32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF};
    load_calib(v);
    add_req(KIND_TEMP, 20'hFFFFF);
    add_req(KIND_PRESS, 20'd0);
    add_req(KIND_TEMP, 20'd0);
    add_req(KIND_PRESS, 20'hFFFFF);
    drain();
    v = '{32'h0, 32'hFFFF_8000, 32'hFFFF_8000, 32'h1,
          32'h8000_8000, 32'h8000_8000, 32'h8000_8000, 32'h8000_8000};
    load_calib(v);
    add_req(KIND_TEMP, 20'hFFFFF);
    add_req(KIND_PRESS, 20'h12345);
    add_req(KIND_TEMP, 20'd0);
    add_req(KIND_PRESS, 20'hFFFFF);
    drain();

    // random phases, mostly near-typical calibration
    for (int ph = 0; ph < 9; ph++) begin
      if (ph % 3 == 2) begin
        for (int i = 0; i < 8; i++) v[i] = $urandom;
        if ($urandom_range(1) == 0) v[REG_P1] = {16'($urandom), 16'd0};
      end else begin
        near_typical(v);
      end
      load_calib(v);
      if (ph == 8) quiet = 1'b1;
      for (int n = 0; n < 205; n++) begin
        if ($urandom_range(9) < 8) add_req(n[0] ? KIND_PRESS : KIND_TEMP,
                                           20'($urandom_range(300000, 700000)));
        else add_req(1'($urandom), 20'($urandom));
      end
      drain();
    end

    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
